>>> hdl/cfd_pkg.sv
`default_nettype none
package cfd_pkg;

	localparam int SAMP_W    = 16;
	localparam int COEF_W    = 18;
	localparam int OUT_W     = 18;
	localparam int PROD_W    = SAMP_W + COEF_W;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int DECIM_W   = 5;
	localparam int TAPS_W    = 9;
	localparam int CADDR_W   = 8;

	// Jobs that may wait between the front and the MAC engine, the active one included.
	localparam int QDEPTH    = 2;

	localparam int OUT_MAX   = 131071;
	localparam int OUT_MIN   = -131072;
	localparam logic [OUT_W-1:0] OUT_MAX_C = 18'h1FFFF;
	localparam logic [OUT_W-1:0] OUT_MIN_C = 18'h20000;

	localparam logic [DECIM_W-1:0] RST_DECIM = 5'd10;
	localparam logic [TAPS_W-1:0]  RST_TAPS  = 9'd200;

	typedef enum logic [1:0] {
		REG_DECIM     = 2'd0,
		REG_TAPS      = 2'd1,
		REG_COEF_ADDR = 2'd2,
		REG_COEF_DATA = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MAC,
		BK_FLUSH,
		BK_SCALE
	} bk_state_t;

	typedef struct packed {
		logic [SAMP_W-1:0] q;
		logic [SAMP_W-1:0] i;
	} sample_pair_t;

	typedef struct packed {
		logic [OUT_W-1:0] out_i;
		logic [OUT_W-1:0] out_q;
		logic             clipped;
		logic             config_error;
	} result_t;

	typedef struct packed {
		logic ready;
		logic err;
	} cfg_stat_t;

endpackage
`default_nettype wire

>>> hdl/cfd_regs.sv
`default_nettype none
module cfd_regs
	import cfd_pkg::*;
#(
	parameter int MAX_TAPS  = 256,
	parameter int MAX_DECIM = 16,
	localparam int MW  = $clog2(MAX_DECIM + 1),
	localparam int TW  = $clog2(MAX_TAPS + 1),
	localparam int CAW = $clog2(MAX_TAPS)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic      [MW-1:0]      m_eff,
	output logic      [TW-1:0]      taps_eff,
	output cfg_stat_t               stat,
	output logic                    coef_we,
	output logic      [CAW-1:0]     coef_waddr,
	output logic      [COEF_W-1:0]  coef_wdata
);

	localparam int CW = $clog2(TW + 1);

	logic [DECIM_W-1:0] decim_q;
	logic [TAPS_W-1:0]  taps_q;
	logic [CADDR_W-1:0] caddr_q;
	logic [COEF_W-1:0]  cdata_q;
	logic               wr;
	reg_idx_t           idx;
	logic [31:0]        dec32;
	logic [31:0]        m32;
	logic [31:0]        tap32;

	logic               load_q;
	logic [CW-1:0]      cnt_q;
	logic [TW-1:0]      div_q;
	logic [MW-1:0]      rem_q;
	logic [MW:0]        cand;

	// Coefficient address reduced modulo the memory depth by restoring subtraction.
	function automatic logic [CAW-1:0] addr_mod(input logic [CADDR_W-1:0] a);
		int r;
		r = int'(a);
		for (int k = CADDR_W - 1; k >= 0; k--) begin
			if (r >= (MAX_TAPS << k)) begin
				r = r - (MAX_TAPS << k);
			end
		end
		return CAW'(r);
	endfunction

	assign wr  = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= RST_DECIM;
			taps_q  <= RST_TAPS;
			caddr_q <= '0;
			cdata_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_DECIM:     decim_q <= pwdata[DECIM_W-1:0];
				REG_TAPS:      taps_q  <= pwdata[TAPS_W-1:0];
				REG_COEF_ADDR: caddr_q <= pwdata[CADDR_W-1:0];
				REG_COEF_DATA: cdata_q <= pwdata[COEF_W-1:0];
				default:       ;
			endcase
		end
	end

	assign coef_we    = wr && (idx == REG_COEF_DATA);
	assign coef_waddr = addr_mod(caddr_q);
	assign coef_wdata = pwdata[COEF_W-1:0];

	always_comb begin
		case (idx)
			REG_DECIM:     prdata = PDATA_W'(decim_q);
			REG_TAPS:      prdata = PDATA_W'(taps_q);
			REG_COEF_ADDR: prdata = PDATA_W'(caddr_q);
			REG_COEF_DATA: prdata = PDATA_W'(cdata_q);
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		dec32 = 32'(decim_q);
		tap32 = 32'(taps_q);
		if (dec32 == 32'd0) begin
			m32 = 32'd1;
		end else if (dec32 > 32'(MAX_DECIM)) begin
			m32 = 32'(MAX_DECIM);
		end else begin
			m32 = dec32;
		end
		if (tap32 > 32'(MAX_TAPS)) begin
			tap32 = 32'(MAX_TAPS);
		end
		m_eff    = MW'(m32);
		taps_eff = TW'(tap32);
	end

	// Bit-serial remainder of taps_eff by m_eff, rerun after reset and after any
	// write to either register.
	assign cand = {rem_q, div_q[TW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else if (wr && (idx == REG_DECIM || idx == REG_TAPS)) begin
			load_q <= 1'b1;
		end else if (load_q) begin
			load_q <= 1'b0;
			cnt_q  <= CW'(TW);
			rem_q  <= '0;
			div_q  <= taps_eff;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
			div_q <= {div_q[TW-2:0], 1'b0};
			if (cand >= {1'b0, m_eff}) begin
				rem_q <= MW'(cand - {1'b0, m_eff});
			end else begin
				rem_q <= cand[MW-1:0];
			end
		end
	end

	assign stat.ready = !load_q && (cnt_q == '0);
	assign stat.err   = (rem_q != '0);

endmodule
`default_nettype wire

>>> hdl/cfd_front.sv
`default_nettype none
module cfd_front
	import cfd_pkg::*;
#(
	parameter int MAX_TAPS  = 256,
	parameter int MAX_DECIM = 16,
	parameter int RING_AW   = 9,
	localparam int MW  = $clog2(MAX_DECIM + 1),
	localparam int TW  = $clog2(MAX_TAPS + 1),
	localparam int PHW = $clog2(MAX_DECIM)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [SAMP_W-1:0]   sample_i,
	input  wire logic [SAMP_W-1:0]   sample_q,
	input  wire logic                block_start,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [MW-1:0]       m_eff,
	input  wire logic [TW-1:0]       taps_eff,
	input  wire cfg_stat_t           stat,
	input  wire logic                q_full,
	output logic                     ring_we,
	output logic      [RING_AW-1:0]  ring_waddr,
	output sample_pair_t             ring_wdata,
	output logic                     job_push,
	output logic      [RING_AW-1:0]  job_wp,
	output logic      [TW-1:0]       job_n,
	output logic                     job_err
);

	logic [RING_AW-1:0] wp_q;
	logic [TW-1:0]      fill_q;
	logic [PHW-1:0]     phase_q;
	logic [PHW-1:0]     phase_cur;
	logic [PHW:0]       phase_inc;
	logic [TW-1:0]      fill_new;
	logic               emit;
	logic               take;

	assign phase_cur = block_start ? '0 : phase_q;
	assign emit      = (phase_cur == '0);
	assign phase_inc = {1'b0, phase_cur} + (PHW + 1)'(1);
	assign in_ready  = stat.ready && !(emit && q_full);
	assign take      = in_valid && in_ready;

	always_comb begin
		if (block_start) begin
			fill_new = TW'(1);
		end else if (fill_q == TW'(MAX_TAPS)) begin
			fill_new = fill_q;
		end else begin
			fill_new = fill_q + TW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			fill_q  <= '0;
			phase_q <= '0;
		end else if (take) begin
			wp_q   <= wp_q + RING_AW'(1);
			fill_q <= fill_new;
			if (32'(phase_inc) >= 32'(m_eff)) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_inc[PHW-1:0];
			end
		end
	end

	assign ring_we      = take;
	assign ring_waddr   = wp_q;
	assign ring_wdata.i = sample_i;
	assign ring_wdata.q = sample_q;

	assign job_push = take && emit;
	assign job_wp   = wp_q;
	assign job_n    = (taps_eff < fill_new) ? taps_eff : fill_new;
	assign job_err  = stat.err;

endmodule
`default_nettype wire

>>> hdl/cfd_queue.sv
`default_nettype none
module cfd_queue
	import cfd_pkg::*;
#(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output logic      [W-1:0] head
);

	localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	logic [W-1:0]   slot_q [QDEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;

	function automatic logic [QPW-1:0] nxt(input logic [QPW-1:0] p);
		return (p == QPW'(QDEPTH - 1)) ? '0 : p + QPW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= nxt(wr_q);
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	assign full       = (cnt_q == QCW'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_q];

endmodule
`default_nettype wire

>>> hdl/cfd_back.sv
`default_nettype none
module cfd_back
	import cfd_pkg::*;
#(
	parameter int MAX_TAPS       = 256,
	parameter int COEF_FRAC_BITS = 17,
	parameter int RING_AW        = 9,
	localparam int TW  = $clog2(MAX_TAPS + 1),
	localparam int CAW = $clog2(MAX_TAPS)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ring_we,
	input  wire logic [RING_AW-1:0] ring_waddr,
	input  wire sample_pair_t       ring_wdata,
	input  wire logic               coef_we,
	input  wire logic [CAW-1:0]     coef_waddr,
	input  wire logic [COEF_W-1:0]  coef_wdata,
	input  wire logic               job_valid,
	input  wire logic [RING_AW-1:0] job_wp,
	input  wire logic [TW-1:0]      job_n,
	input  wire logic               job_err,
	output logic                    job_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output result_t                 out_res
);

	localparam int ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;
	localparam int RD    = 2 ** RING_AW;
	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

	sample_pair_t              ring_mem [RD];
	logic [COEF_W-1:0]         coef_mem [MAX_TAPS];

	bk_state_t                 state_q;
	bk_state_t                 state_d;
	logic [TW-1:0]             t_q;
	logic                      issue;
	logic                      acc_clr;
	logic                      done;
	logic                      out_free;
	logic [RING_AW-1:0]        raddr;

	logic                      v_s1;
	logic                      v_s2;
	logic [COEF_W-1:0]         coef_s1;
	sample_pair_t              smp_s1;
	logic signed [PROD_W-1:0]  prod_i_s2;
	logic signed [PROD_W-1:0]  prod_q_s2;
	logic signed [ACC_W-1:0]   acc_i_q;
	logic signed [ACC_W-1:0]   acc_q_q;
	logic [OUT_W:0]            sat_i;
	logic [OUT_W:0]            sat_q;
	result_t                   res;
	logic                      out_valid_q;
	result_t                   out_res_q;

	function automatic logic [OUT_W:0] round_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] v;
		logic signed [ACC_W-1:0] s;
		logic [OUT_W:0]          r;
		v = a + RND;
		s = v >>> COEF_FRAC_BITS;
		if (s > SAT_HI) begin
			r = {1'b1, OUT_MAX_C};
		end else if (s < SAT_LO) begin
			r = {1'b1, OUT_MIN_C};
		end else begin
			r = {1'b0, s[OUT_W-1:0]};
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		if (coef_we) begin
			coef_mem[coef_waddr] <= coef_wdata;
		end
	end

	assign raddr = job_wp - RING_AW'(t_q);

	always_ff @(posedge clk) begin
		if (issue) begin
			coef_s1 <= coef_mem[t_q[CAW-1:0]];
			smp_s1  <= ring_mem[raddr];
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					if (job_err || job_n == '0) begin
						state_d = BK_SCALE;
					end else begin
						state_d = BK_MAC;
					end
				end
			end
			BK_MAC: begin
				if (t_q == job_n - TW'(1)) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (!v_s1 && !v_s2) begin
					state_d = BK_SCALE;
				end
			end
			BK_SCALE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		issue   = 1'b0;
		acc_clr = 1'b0;
		done    = 1'b0;
		case (state_q)
			BK_IDLE:  acc_clr = 1'b1;
			BK_MAC:   issue   = 1'b1;
			BK_FLUSH: ;
			BK_SCALE: done    = out_free;
			default:  ;
		endcase
	end

	assign job_pop = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			t_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			if (issue) begin
				t_q <= t_q + TW'(1);
			end else if (acc_clr) begin
				t_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_i_s2 <= $signed(coef_s1) * $signed(smp_s1.i);
		prod_q_s2 <= $signed(coef_s1) * $signed(smp_s1.q);
		if (acc_clr) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (v_s2) begin
			acc_i_q <= acc_i_q + {{(ACC_W - PROD_W){prod_i_s2[PROD_W-1]}}, prod_i_s2};
			acc_q_q <= acc_q_q + {{(ACC_W - PROD_W){prod_q_s2[PROD_W-1]}}, prod_q_s2};
		end
	end

	assign sat_i = round_sat(acc_i_q);
	assign sat_q = round_sat(acc_q_q);

	always_comb begin
		if (job_err) begin
			res.out_i        = '0;
			res.out_q        = '0;
			res.clipped      = 1'b0;
			res.config_error = 1'b1;
		end else begin
			res.out_i        = sat_i[OUT_W-1:0];
			res.out_q        = sat_q[OUT_W-1:0];
			res.clipped      = sat_i[OUT_W] || sat_q[OUT_W];
			res.config_error = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule
`default_nettype wire

>>> hdl/complex_fir_decimator.sv
`default_nettype none
// Complex FIR decimator. Each input beat carries one I/Q sample; on every
// decimation-th sample of a block (the first sample of a block is always an
// output phase) one output beat carries y = sum h[t]*x[m-t] for both
// components, rounded half up, shifted right by COEF_FRAC_BITS and saturated
// to 18 bits, with clipped set when either component hit a rail. Samples
// before block_start count as zero. Coefficients are loaded through the APB
// port by writing coef_addr (register 2, byte 0x8) and then coef_data
// (register 3, byte 0xC); each coef_data write stores one coefficient, with no
// auto increment. decimation is register 0 (0x0) and num_taps register 1
// (0x4). When num_taps is not a multiple of decimation the output beat
// carries zeros with config_error set. Timing: samples that produce no output
// are taken one per cycle while the multiple check is not running. A sample
// that produces an output queues a job for the single shared
// multiply-accumulate engine, which steps through n taps, where n is the
// smaller of num_taps and the samples seen since block start; the engine sets
// the sustained input rate. Two jobs may be queued, so the input keeps flowing
// while a result waits on the output. Every write to decimation or num_taps
// holds in_ready low while the multiple check reruns, and the same check runs
// once after reset.
module complex_fir_decimator
	import cfd_pkg::*;
#(
	parameter int MAX_TAPS       = 256,
	parameter int MAX_DECIM      = 16,
	parameter int COEF_FRAC_BITS = 17
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic [SAMP_W-1:0]  sample_i,
	input  wire logic [SAMP_W-1:0]  sample_q,
	input  wire logic               block_start,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic      [OUT_W-1:0]   out_i,
	output logic      [OUT_W-1:0]   out_q,
	output logic                    clipped,
	output logic                    config_error,
	output logic                    out_valid,
	input  wire logic               out_ready
);

	localparam int MW      = $clog2(MAX_DECIM + 1);
	localparam int TW      = $clog2(MAX_TAPS + 1);
	localparam int CAW     = $clog2(MAX_TAPS);
	// The sample ring is deep enough that the front, running ahead by at most
	// the queued jobs' worth of samples, never overwrites a sample the engine
	// still has to read.
	localparam int RING_AW = $clog2(MAX_TAPS + QDEPTH * MAX_DECIM);
	localparam int JOB_W   = RING_AW + TW + 1;

	logic [MW-1:0]      m_eff;
	logic [TW-1:0]      taps_eff;
	cfg_stat_t          stat;
	logic               coef_we;
	logic [CAW-1:0]     coef_waddr;
	logic [COEF_W-1:0]  coef_wdata;

	logic               ring_we;
	logic [RING_AW-1:0] ring_waddr;
	sample_pair_t       ring_wdata;

	logic               job_push;
	logic [RING_AW-1:0] push_wp;
	logic [TW-1:0]      push_n;
	logic               push_err;
	logic               q_full;
	logic               job_valid;
	logic [JOB_W-1:0]   job_head;
	logic               job_pop;
	result_t            res;

	assign pready = 1'b1;

	cfd_regs #(
		.MAX_TAPS  (MAX_TAPS),
		.MAX_DECIM (MAX_DECIM)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.m_eff      (m_eff),
		.taps_eff   (taps_eff),
		.stat       (stat),
		.coef_we    (coef_we),
		.coef_waddr (coef_waddr),
		.coef_wdata (coef_wdata)
	);

	// The front stores each sample, tracks the output phase and the history
	// fill, and hands a job to the engine for every output phase.
	cfd_front #(
		.MAX_TAPS  (MAX_TAPS),
		.MAX_DECIM (MAX_DECIM),
		.RING_AW   (RING_AW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_i    (sample_i),
		.sample_q    (sample_q),
		.block_start (block_start),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.m_eff       (m_eff),
		.taps_eff    (taps_eff),
		.stat        (stat),
		.q_full      (q_full),
		.ring_we     (ring_we),
		.ring_waddr  (ring_waddr),
		.ring_wdata  (ring_wdata),
		.job_push    (job_push),
		.job_wp      (push_wp),
		.job_n       (push_n),
		.job_err     (push_err)
	);

	cfd_queue #(
		.W (JOB_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.din        ({push_wp, push_n, push_err}),
		.full       (q_full),
		.pop        (job_pop),
		.head_valid (job_valid),
		.head       (job_head)
	);

	// The engine keeps a job at the head of the queue until its result has
	// moved into the output register.
	cfd_back #(
		.MAX_TAPS       (MAX_TAPS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.RING_AW        (RING_AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata),
		.coef_we    (coef_we),
		.coef_waddr (coef_waddr),
		.coef_wdata (coef_wdata),
		.job_valid  (job_valid),
		.job_wp     (job_head[JOB_W-1 -: RING_AW]),
		.job_n      (job_head[TW:1]),
		.job_err    (job_head[0]),
		.job_pop    (job_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (res)
	);

	assign out_i        = res.out_i;
	assign out_q        = res.out_q;
	assign clipped      = res.clipped;
	assign config_error = res.config_error;

endmodule
`default_nettype wire

>>> hdl/cfd_checker.sv
`default_nettype none
module cfd_checker
	import cfd_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               psel,
	input wire logic               penable,
	input wire logic               pwrite,
	input wire logic               pready,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [OUT_W-1:0]   out_i,
	input wire logic [OUT_W-1:0]   out_q,
	input wire logic               clipped,
	input wire logic               config_error
);

	// A result beat that is held back keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_i) && $stable(out_q)
			&& $stable(clipped) && $stable(config_error))
		else $error("output beat changed while stalled");

	// A configuration error beat carries zeros and no clip.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> out_i == '0 && out_q == '0 && !clipped)
		else $error("config error beat with nonzero payload");

	// Clipping means at least one component sits on a rail.
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> out_i == OUT_MAX_C || out_i == OUT_MIN_C
			|| out_q == OUT_MAX_C || out_q == OUT_MIN_C)
		else $error("clipped set with no saturated component");

	// Changing decimation or num_taps reruns the multiple check and holds input.
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready
			&& (paddr[3:2] == REG_DECIM || paddr[3:2] == REG_TAPS) |=> !in_ready)
		else $error("input accepted during configuration check");

endmodule

bind complex_fir_decimator cfd_checker u_cfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.pready       (pready),
	.paddr        (paddr),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_i        (out_i),
	.out_q        (out_q),
	.clipped      (clipped),
	.config_error (config_error)
);
`default_nettype wire

>>> test/decimator_output_checker.sv
`timescale 1ns / 1ps

// Watches the register port and both streaming channels of the decimator.
// Register writes and accepted samples feed a bit-exact model of the filter;
// every output beat is compared against the oldest predicted result.
module decimator_output_checker
	import cfd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic               pready,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	input  wire logic [SAMP_W-1:0]  sample_i,
	input  wire logic [SAMP_W-1:0]  sample_q,
	input  wire logic               block_start,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [OUT_W-1:0]   out_i,
	input  wire logic [OUT_W-1:0]   out_q,
	input  wire logic               clipped,
	input  wire logic               config_error,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	output int                      fail_count,
	output int                      pending,
	output int                      beats_checked
);

	localparam int FIR_DEPTH   = 256;
	localparam int DECIM_LIMIT = 16;
	localparam int FRAC_BITS   = 17;
	localparam int PRINT_LIMIT = 100;

	logic signed [SAMP_W-1:0] hist_i [FIR_DEPTH];
	logic signed [SAMP_W-1:0] hist_q [FIR_DEPTH];
	logic signed [COEF_W-1:0] coef_mem [FIR_DEPTH];
	logic [7:0]               wr_ptr;
	int                       fill_cnt;
	int                       phase_cnt;

	logic [DECIM_W-1:0] decim_reg;
	logic [TAPS_W-1:0]  taps_reg;
	logic [CADDR_W-1:0] caddr_reg;

	result_t expected_outputs [$];
	int      mismatch_total;
	int      checked_total;

	task automatic report_mismatch(input string what);
		if (mismatch_total < PRINT_LIMIT)
			$display("[%0t] output mismatch: %s", $time, what);
		mismatch_total++;
	endtask

	// Round half up, drop the fraction bits and clamp to the 18-bit output range.
	function automatic logic [OUT_W-1:0] round_and_clip(input longint acc, inout bit clip);
		longint q;
		q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (q > OUT_MAX) begin
			clip = 1'b1;
			return OUT_MAX_C;
		end
		if (q < OUT_MIN) begin
			clip = 1'b1;
			return OUT_MIN_C;
		end
		return q[OUT_W-1:0];
	endfunction

	function automatic void predict_decimated_output(input logic [SAMP_W-1:0] si,
			input logic [SAMP_W-1:0] sq, input logic first);
		int         m_eff;
		int         taps;
		int         n;
		longint     acc_i;
		longint     acc_q;
		logic [7:0] pos;
		bit         clip;
		result_t    r;
		m_eff = (decim_reg == 0) ? 1 : ((decim_reg > DECIM_LIMIT) ? DECIM_LIMIT : int'(decim_reg));
		taps = (taps_reg > FIR_DEPTH) ? FIR_DEPTH : int'(taps_reg);
		if (first) begin
			fill_cnt = 0;
			phase_cnt = 0;
		end
		hist_i[wr_ptr] = si;
		hist_q[wr_ptr] = sq;
		if (fill_cnt < FIR_DEPTH)
			fill_cnt++;
		if (phase_cnt == 0) begin
			r = '0;
			clip = 1'b0;
			r.config_error = (taps % m_eff) != 0;
			if (!r.config_error) begin
				acc_i = 0;
				acc_q = 0;
				n = (taps < fill_cnt) ? taps : fill_cnt;
				for (int t = 0; t < n; t++) begin
					pos = wr_ptr - 8'(t);
					acc_i += longint'(coef_mem[t]) * longint'(hist_i[pos]);
					acc_q += longint'(coef_mem[t]) * longint'(hist_q[pos]);
				end
				r.out_i = round_and_clip(acc_i, clip);
				r.out_q = round_and_clip(acc_q, clip);
			end
			r.clipped = clip;
			expected_outputs = {expected_outputs, r};
		end
		phase_cnt++;
		if (phase_cnt >= m_eff)
			phase_cnt = 0;
		wr_ptr++;
	endfunction

	task automatic apply_register_write(input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		case (reg_idx_t'(addr[PADDR_W-1:2]))
			REG_DECIM:     decim_reg = data[DECIM_W-1:0];
			REG_TAPS:      taps_reg = data[TAPS_W-1:0];
			REG_COEF_ADDR: caddr_reg = data[CADDR_W-1:0];
			REG_COEF_DATA: coef_mem[caddr_reg] = data[COEF_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_output_beat();
		result_t want;
		if (expected_outputs.size() == 0) begin
			report_mismatch($sformatf("beat with no result pending (out_i %0d out_q %0d)",
				$signed(out_i), $signed(out_q)));
		end else begin
			want = expected_outputs.pop_front();
			checked_total++;
			if (out_i !== want.out_i)
				report_mismatch($sformatf("out_i %0d, expected %0d",
					$signed(out_i), $signed(want.out_i)));
			if (out_q !== want.out_q)
				report_mismatch($sformatf("out_q %0d, expected %0d",
					$signed(out_q), $signed(want.out_q)));
			if (clipped !== want.clipped)
				report_mismatch($sformatf("clipped %b, expected %b", clipped, want.clipped));
			if (config_error !== want.config_error)
				report_mismatch($sformatf("config_error %b, expected %b",
					config_error, want.config_error));
		end
	endtask

	// Outputs are checked before the input beat of the same edge is predicted,
	// since a result can never leave in the cycle its sample arrives.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr = '0;
			fill_cnt = 0;
			phase_cnt = 0;
			decim_reg = RST_DECIM;
			taps_reg = RST_TAPS;
			caddr_reg = '0;
			expected_outputs.delete();
		end else begin
			if (psel && penable && pwrite && pready)
				apply_register_write(paddr, pwdata);
			if (out_valid && out_ready)
				check_output_beat();
			if (in_valid && in_ready)
				predict_decimated_output(sample_i, sample_q, block_start);
		end
		pending <= expected_outputs.size();
		fail_count <= mismatch_total;
		beats_checked <= checked_total;
	end

endmodule

>>> test/tb_complex_fir_decimator.sv
`timescale 1ns / 1ps

// Top of the decimator regression. This module only produces stimulus and the
// verdict; the checker instance beside the block predicts and compares every
// output beat.
module tb_complex_fir_decimator;
	import cfd_pkg::*;

	// Cycles to let pass once every expected result has arrived, so that a
	// trailing sample with no output of its own is surely stored before the
	// registers change.
	localparam int SETTLE_CYCLES = 32;
	// One full 256-tap job plus its overhead, used for the quiet tail at the end.
	localparam int TAIL_CYCLES   = 300;
	// Length of the single long output stall used to back the block up.
	localparam int HOLD_CYCLES   = 200;
	localparam int RANDOM_ITEMS  = 400;
	localparam int MIN_RESULTS   = 48;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic [SAMP_W-1:0]  sample_i;
	logic [SAMP_W-1:0]  sample_q;
	logic               block_start;
	logic               in_valid;
	logic               in_ready;
	logic [OUT_W-1:0]   out_i;
	logic [OUT_W-1:0]   out_q;
	logic               clipped;
	logic               config_error;
	logic               out_valid;
	logic               out_ready;

	int  fail_count;
	int  pending;
	int  beats_checked;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  random_items;
	logic hold_req;
	bit  hold_done;

	complex_fir_decimator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.sample_i    (sample_i),
		.sample_q    (sample_q),
		.block_start (block_start),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_i       (out_i),
		.out_q       (out_q),
		.clipped     (clipped),
		.config_error(config_error),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

	decimator_output_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.sample_i     (sample_i),
		.sample_q     (sample_q),
		.block_start  (block_start),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.out_i        (out_i),
		.out_q        (out_q),
		.clipped      (clipped),
		.config_error (config_error),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fail_count   (fail_count),
		.pending      (pending),
		.beats_checked(beats_checked)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("complex_fir_decimator regression: fail");
		$finish;
	end

	// Output side. Each cycle out_ready is rolled against the stall rate of the
	// current phase. When the pressure phase asks for it, the receiver refuses
	// beats for a long stretch so the job queue fills and in_ready drops.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// APB write: setup, then access. The register takes the value at the edge
	// that closes the access cycle, and the bus is released right after, so
	// back-to-back writes leave the bus idle between them.
	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Coefficients have no auto increment, so each one needs its own address.
	task automatic load_coefficient(input logic [CADDR_W-1:0] addr,
			input logic [COEF_W-1:0] value);
		reg_write(REG_COEF_ADDR, PDATA_W'(addr));
		reg_write(REG_COEF_DATA, PDATA_W'(value));
	endtask

	task automatic set_filter(input logic [DECIM_W-1:0] decim, input logic [TAPS_W-1:0] taps);
		reg_write(REG_DECIM, PDATA_W'(decim));
		reg_write(REG_TAPS, PDATA_W'(taps));
	endtask

	// Offers one sample beat. On entry we sit right after an edge; valid is
	// either still high from the previous beat or low. A sender gap lowers valid
	// in this step and raises it only at a later edge, so valid never gets two
	// assignments in one time step. Returns at the edge that accepts the beat.
	task automatic offer_sample(input logic [SAMP_W-1:0] si, input logic [SAMP_W-1:0] sq,
			input logic first);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		sample_i <= si;
		sample_q <= sq;
		block_start <= first;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops the sender and waits until every predicted output has been checked,
	// then lets the block settle before the registers are touched again.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle_mode(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 55;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 55;
			end
			default: begin
				send_idle_pct = 22;
				recv_stall_pct = 22;
			end
		endcase
	endtask

	// Mostly random words, with the rails and zero mixed in often enough to
	// drive the accumulators into saturation now and then.
	function automatic logic [SAMP_W-1:0] pick_sample();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return SAMP_W'($urandom);
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_coefficient();
		case ($urandom_range(9))
			0: return 18'h20000;
			1: return 18'h1FFFF;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	// Picks a decimation factor and a tap count for one random phase. Most
	// phases get a short, valid filter; some get the longest one, some a tap
	// count that is not a multiple of the factor, and some values that lie
	// outside the nominal ranges. A few coefficients are reloaded each time.
	task automatic configure_random_filter();
		int                 roll;
		int                 m_eff;
		int                 kmax;
		logic [DECIM_W-1:0] decim;
		logic [TAPS_W-1:0]  taps;
		roll = $urandom_range(99);
		if (roll < 5)
			decim = '0;
		else if (roll < 10)
			decim = DECIM_W'($urandom_range(17, 31));
		else if (roll < 20)
			decim = 5'd16;
		else
			decim = DECIM_W'($urandom_range(1, 8));
		m_eff = (decim == 0) ? 1 : ((decim > 16) ? 16 : int'(decim));
		kmax = 256 / m_eff;
		roll = $urandom_range(99);
		if (roll < 8)
			taps = TAPS_W'(kmax * m_eff);
		else if (roll < 18 && m_eff > 1)
			taps = TAPS_W'(m_eff * $urandom_range(1, 4) + $urandom_range(1, m_eff - 1));
		else if (roll < 22)
			taps = '0;
		else if (roll < 26)
			taps = TAPS_W'($urandom_range(257, 511));
		else
			taps = TAPS_W'(m_eff * $urandom_range(1, (kmax < 8) ? kmax : 8));
		set_filter(decim, taps);
		repeat ($urandom_range(1, 4))
			load_coefficient(CADDR_W'($urandom), pick_coefficient());
	endtask

	// Random traffic for one phase. Most of it is whole blocks, each opened by a
	// block_start beat; about one pick in ten is a loose sample whose
	// block_start is random, which breaks blocks at arbitrary points. Rarely a
	// block runs past MAX_TAPS samples so the history count saturates.
	task automatic run_random_blocks(input int budget);
		int len;
		while (budget > 0) begin
			if ($urandom_range(9) == 0) begin
				offer_sample(pick_sample(), pick_sample(), 1'($urandom));
				budget--;
				random_items++;
			end else begin
				len = ($urandom_range(49) == 0) ? $urandom_range(260, 300) : $urandom_range(1, 40);
				for (int k = 0; k < len; k++) begin
					offer_sample(pick_sample(), pick_sample(), k == 0);
					random_items++;
				end
				budget -= len;
			end
		end
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_i = '0;
		sample_q = '0;
		block_start = 1'b0;
		in_valid = 1'b0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Fill the whole coefficient memory so no tap ever reads an empty entry.
		// The first eight taps sit on the negative rail and tap eight on the
		// positive one, which makes the directed sums easy to push into clipping.
		for (int a = 0; a < 256; a++) begin
			if (a < 8)
				load_coefficient(CADDR_W'(a), 18'h20000);
			else if (a == 8)
				load_coefficient(CADDR_W'(a), 18'h1FFFF);
			else
				load_coefficient(CADDR_W'(a), pick_coefficient());
		end

		// Directed: one output per sample over eight taps. A block of rail
		// samples grows from a single-sample history until the I sum clips high
		// and the Q sum clips low; then a fresh block restarts the history.
		set_filter(5'd1, 9'd8);
		for (int k = 0; k < 8; k++)
			offer_sample(16'h8000, 16'h7FFF, k == 0);
		offer_sample(16'h7FFF, 16'h8000, 1'b1);
		offer_sample(16'h0000, 16'h0000, 1'b0);
		offer_sample(16'h0001, 16'hFFFF, 1'b0);
		offer_sample(16'hFFFF, 16'h0001, 1'b0);
		wait_for_idle();

		// Directed: seven taps with a factor of four is a configuration error,
		// so the output phases carry zeros with config_error set.
		set_filter(5'd4, 9'd7);
		for (int k = 0; k < 5; k++)
			offer_sample(pick_sample(), pick_sample(), k == 0);
		wait_for_idle();

		// Directed: a zero factor behaves as one, and zero taps give an empty sum.
		set_filter(5'd0, 9'd0);
		for (int k = 0; k < 3; k++)
			offer_sample(pick_sample(), pick_sample(), k == 0);
		wait_for_idle();

		// Directed: both fields beyond their ranges clamp to sixteen and 256,
		// which is a valid pairing. The last coefficient address and both data
		// rails are exercised here as well.
		load_coefficient(8'd255, 18'h1FFFF);
		load_coefficient(8'd0, 18'h20000);
		set_filter(5'd31, 9'd511);
		offer_sample(16'h7FFF, 16'h8000, 1'b1);
		offer_sample(pick_sample(), pick_sample(), 1'b0);
		wait_for_idle();

		// Directed: the largest nominal factor with a single tap.
		set_filter(5'd16, 9'd1);
		offer_sample(16'h8000, 16'h7FFF, 1'b1);
		offer_sample(pick_sample(), pick_sample(), 1'b0);
		wait_for_idle();

		// Back pressure: every sample yields a short job, the receiver refuses
		// beats for a long stretch, and the sender keeps offering with no gaps.
		set_idle_mode(IDLE_NONE);
		set_filter(5'd1, 9'd4);
		hold_req <= 1'b1;
		for (int k = 0; k < 40; k++)
			offer_sample(pick_sample(), pick_sample(), k == 0);
		wait_for_idle();

		// Random phases, cycling through the idle patterns, until enough samples
		// went in and enough results came back.
		phase = 0;
		while (random_items < RANDOM_ITEMS || beats_checked < MIN_RESULTS) begin
			set_idle_mode(idle_mode_t'(phase % 4));
			configure_random_filter();
			run_random_blocks($urandom_range(40, 60));
			wait_for_idle();
			phase++;
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("complex_fir_decimator regression: pass");
		else
			$display("complex_fir_decimator regression: fail");
		$finish;
	end

endmodule
